// File: src/prfl_pkg.sv
// ----------------------------------------------------------------------------
// prfl_pkg - shared types and constants for the page replacement unit
// Transaction structs, configuration register indexes, sequencer states and
// rank unit operation codes.
// ----------------------------------------------------------------------------
package prfl_pkg;

  // default sizes
  localparam int VIRTUAL_PAGES_DEF = 16;
  localparam int FRAMES_DEF        = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;
  localparam logic [3:0]           FRAMES_IN_USE_RST = 4'd8;

  localparam logic [15:0] HIT_MAX = 16'hFFFF;

  typedef enum logic {
    POLICY_FIFO = 1'b0,
    POLICY_LRU  = 1'b1
  } policy_t;

  typedef struct packed {
    logic [3:0] virtual_page;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  frame;
    logic        evicted_valid;
    logic [3:0]  evicted_page;
    logic [15:0] hit_total;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_PICK,
    ST_FETCH,
    ST_APPLY,
    ST_TOUCH,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RK_HOLD,
    RK_SCAN,
    RK_TOUCH,
    RK_ZERO
  } rk_op_t;

  typedef struct packed {
    rk_op_t op;
    logic   first;      // first element of a scan
    logic   all_older;  // touch ages every other frame (free-frame load)
  } rk_ctrl_t;

endpackage

// File: src/prfl_rank_unit.sv
// ----------------------------------------------------------------------------
// prfl_rank_unit - recency rank store with compare and increment logic
// One rank is read per cycle; the same read port serves the LRU victim scan
// and the ageing sweep that makes a frame the most recent.
// ----------------------------------------------------------------------------
module prfl_rank_unit #(
  parameter int FRAMES = prfl_pkg::FRAMES_DEF,
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic               clk,
  input  prfl_pkg::rk_ctrl_t ctrl,
  input  logic [FW-1:0]      rd_addr,
  input  logic [FW-1:0]      idx,
  input  logic [FW-1:0]      frame,
  input  logic [FW-1:0]      old_rank,
  output logic [FW-1:0]      rd_q,
  output logic [FW-1:0]      best_idx
);
  import prfl_pkg::*;

  logic [FW-1:0] rank_mem [FRAMES];
  logic [FW-1:0] rd_q_r;
  logic [FW-1:0] best_idx_r;
  logic [FW-1:0] best_rank_r;

  // rd_q_r holds the rank of the element addressed last cycle
  always_ff @(posedge clk) begin
    rd_q_r <= rank_mem[rd_addr];
    case (ctrl.op)
      RK_TOUCH: begin
        if (idx != frame && (ctrl.all_older || rd_q_r < old_rank)) begin
          rank_mem[idx] <= FW'(rd_q_r + 1'b1);
        end
      end
      RK_ZERO: begin
        rank_mem[frame] <= '0;
      end
      default: begin
      end
    endcase
  end

  // LRU search: strict compare keeps the lowest frame on a tie
  always_ff @(posedge clk) begin
    if (ctrl.op == RK_SCAN && (ctrl.first || rd_q_r > best_rank_r)) begin
      best_idx_r  <= idx;
      best_rank_r <= rd_q_r;
    end
  end

  assign rd_q     = rd_q_r;
  assign best_idx = best_idx_r;

endmodule

// File: src/page_replacement_fifo_lru.sv
// ----------------------------------------------------------------------------
// page_replacement_fifo_lru - page table with FIFO / LRU frame replacement
// Looks up each page access, loads free frames in order and replaces a victim
// frame by the selected policy when all usable frames are taken.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a transaction is taken at a rising edge with start high and
//   busy low; in_data carries the page number and the last flag. busy stays
//   high until the result has been shown.
//   Result channel: out_valid is high for exactly one cycle with out_data; the
//   receiver cannot stall, so the result must be taken in that cycle.
//   Configuration: cfg_we with cfg_index / cfg_data writes policy_mode (0) or
//   frames_in_use (1); other indexes are ignored. The user is to write only
//   while busy is low; the block itself does not enforce this.
// Sequence: an access passes LOOK, FETCH, APPLY, a TOUCH sweep over filled
//   frames and DONE, which shows the result; the next transaction is taken
//   once back in IDLE. LRU replacement adds a SCAN over all filled frames
//   and a PICK step before FETCH. The scan and the age sweep handle one frame
//   per cycle through the single rank memory port.
// Reset: synchronous, active low; clears residency, fill count, FIFO pointer,
//   hit count, state and config. Page map, owner and rank memories
//   are not cleared: entries are only read once the fill state says they are
//   written. A last transaction clears the first four after its result.
// ----------------------------------------------------------------------------
module page_replacement_fifo_lru #(
  parameter int VIRTUAL_PAGES = prfl_pkg::VIRTUAL_PAGES_DEF,
  parameter int FRAMES        = prfl_pkg::FRAMES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  prfl_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  output prfl_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [prfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [prfl_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import prfl_pkg::*;

  localparam int PW = $clog2(VIRTUAL_PAGES);
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);

  // configuration registers
  policy_t    policy_r;
  logic [3:0] frames_in_use_r;

  // sequencer and per-sequence state
  state_t          state_r, state_nxt;
  logic [VIRTUAL_PAGES-1:0] resident_r;
  logic [VIRTUAL_PAGES-1:0] resident_apply;
  logic [CW-1:0]   filled_r;
  logic [FW-1:0]   fifo_r;
  logic [15:0]     hit_cnt_r;

  // per-transaction working registers
  logic [PW-1:0]   page_r;
  logic            last_r;
  logic            hit_r;
  logic            load_r;
  logic            ev_valid_r;
  logic [PW-1:0]   ev_page_r;
  logic [FW-1:0]   frame_r;
  logic [FW-1:0]   old_r;
  logic [FW-1:0]   idx_r;

  // memories
  logic [FW-1:0]   map_mem   [VIRTUAL_PAGES];
  logic [PW-1:0]   owner_mem [FRAMES];
  logic [FW-1:0]   map_q_r;
  logic [PW-1:0]   owner_q_r;

  // page number folded into the page range: constant table
  logic [PW-1:0]   pmod_tbl [16];
  logic [PW-1:0]   in_page;

  for (genvar g = 0; g < 16; g++) begin : g_pmod
    assign pmod_tbl[g] = PW'(g % VIRTUAL_PAGES);
  end
  assign in_page = pmod_tbl[in_data.virtual_page];

  // rank unit interface
  rk_ctrl_t        rk_ctrl;
  logic [FW-1:0]   rk_rd_addr;
  logic [FW-1:0]   rk_rd_q;
  logic [FW-1:0]   rk_best_idx;

  prfl_rank_unit #(
    .FRAMES (FRAMES)
  ) u_rank (
    .clk       (clk),
    .ctrl      (rk_ctrl),
    .rd_addr   (rk_rd_addr),
    .idx       (idx_r),
    .frame     (frame_r),
    .old_rank  (old_r),
    .rd_q      (rk_rd_q),
    .best_idx  (rk_best_idx)
  );

  // derived decisions
  logic [7:0]    fin8;
  logic [7:0]    usable8;
  logic          is_hit;
  logic          has_free;
  logic          idx_last;
  logic [FW-1:0] fifo_victim;
  logic [CW:0]   fifo_inc;

  always_comb begin
    fin8 = {4'b0, frames_in_use_r};
    if (fin8 == 8'd0) begin
      usable8 = 8'd1;
    end else if (fin8 > 8'(FRAMES)) begin
      usable8 = 8'(FRAMES);
    end else begin
      usable8 = fin8;
    end
  end

  assign is_hit      = resident_r[page_r];
  assign has_free    = 8'(filled_r) < usable8;
  assign idx_last    = 8'(idx_r) == 8'(filled_r) - 8'd1;
  assign fifo_victim = (8'(fifo_r) < 8'(filled_r)) ? fifo_r : '0;
  assign fifo_inc    = (CW+1)'(fifo_victim) + 1'b1;

  // residency after the apply step: evicted page out, new page in
  always_comb begin
    resident_apply = resident_r;
    if (ev_valid_r) resident_apply[owner_q_r] = 1'b0;
    if (!hit_r)     resident_apply[page_r]    = 1'b1;
  end

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_LOOK;
      ST_LOOK: begin
        if (!is_hit && !has_free && policy_r == POLICY_LRU) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_SCAN:  if (idx_last) state_nxt = ST_PICK;
      ST_PICK:  state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_APPLY;
      ST_APPLY: state_nxt = ST_TOUCH;
      ST_TOUCH: if (idx_last) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs ----------------
  // Rank reads are issued ahead: the address given here is the
  // element whose rank the unit presents in the next state.
  always_comb begin
    rk_ctrl.op        = RK_HOLD;
    rk_ctrl.first     = (idx_r == '0);
    rk_ctrl.all_older = load_r;
    rk_rd_addr        = frame_r;
    case (state_r)
      ST_LOOK:  rk_rd_addr = '0;
      ST_SCAN: begin
        rk_ctrl.op = RK_SCAN;
        rk_rd_addr = FW'(idx_r + 1'b1);
      end
      ST_APPLY: rk_rd_addr = '0;
      ST_TOUCH: begin
        rk_ctrl.op = RK_TOUCH;
        rk_rd_addr = FW'(idx_r + 1'b1);
      end
      ST_DONE:  rk_ctrl.op = RK_ZERO;   // touched frame becomes most recent
      default: begin
      end
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

  // ---------------- control state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      policy_r        <= POLICY_FIFO;
      frames_in_use_r <= FRAMES_IN_USE_RST;
      resident_r      <= '0;
      filled_r        <= '0;
      fifo_r          <= '0;
      hit_cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_POLICY_MODE) begin
          policy_r <= policy_t'(cfg_data[0]);
        end else if (cfg_index == CFG_FRAMES_IN_USE) begin
          frames_in_use_r <= cfg_data[3:0];
        end
      end
      case (state_r)
        ST_LOOK: begin
          if (is_hit) begin
            if (hit_cnt_r != HIT_MAX) hit_cnt_r <= hit_cnt_r + 16'd1;
          end else if (!has_free && policy_r == POLICY_FIFO) begin
            // pointer wraps at the fill count
            if (fifo_inc >= (CW+1)'(filled_r)) begin
              fifo_r <= '0;
            end else begin
              fifo_r <= FW'(fifo_inc);
            end
          end
        end
        ST_APPLY: begin
          resident_r <= resident_apply;
          if (load_r) filled_r <= CW'(filled_r + 1'b1);
        end
        ST_DONE: begin
          if (last_r) begin
            resident_r <= '0;
            filled_r   <= '0;
            fifo_r     <= '0;
            hit_cnt_r  <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- transaction working registers ----------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          page_r <= in_page;
          last_r <= in_data.last;
        end
      end
      ST_LOOK: begin
        hit_r      <= is_hit;
        load_r     <= 1'b0;
        ev_valid_r <= 1'b0;
        ev_page_r  <= '0;
        idx_r      <= '0;
        if (is_hit) begin
          frame_r <= map_q_r;
        end else if (has_free) begin
          frame_r <= FW'(filled_r);
          load_r  <= 1'b1;
        end else begin
          ev_valid_r <= 1'b1;
          frame_r    <= fifo_victim;   // LRU overwrites this after the scan
        end
      end
      ST_SCAN:  idx_r   <= FW'(idx_r + 1'b1);
      ST_PICK:  frame_r <= rk_best_idx;
      ST_APPLY: begin
        old_r <= rk_rd_q;
        idx_r <= '0;
        if (ev_valid_r) ev_page_r <= owner_q_r;
      end
      ST_TOUCH: idx_r <= FW'(idx_r + 1'b1);
      default: begin
      end
    endcase
  end

  // ---------------- page map and frame owner memories ----------------
  always_ff @(posedge clk) begin
    map_q_r <= map_mem[in_page];
    if (state_r == ST_APPLY && !hit_r) begin
      map_mem[page_r] <= frame_r;
    end
  end

  always_ff @(posedge clk) begin
    owner_q_r <= owner_mem[frame_r];
    if (state_r == ST_APPLY && !hit_r) begin
      owner_mem[frame_r] <= page_r;
    end
  end

  // ---------------- result ----------------
  logic [FW+2:0] frame_wide;
  logic [PW+3:0] ev_wide;

  assign frame_wide = {3'b0, frame_r};
  assign ev_wide    = {4'b0, ev_page_r};

  always_comb begin
    out_data.hit           = hit_r;
    out_data.frame         = frame_wide[2:0];
    out_data.evicted_valid = ev_valid_r;
    out_data.evicted_page  = ev_wide[3:0];
    out_data.hit_total     = hit_cnt_r;
  end

  // ---------------- assertions ----------------
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe straight after accept");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hit) |-> !out_data.evicted_valid)
    else $error("eviction reported on a hit");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    8'(filled_r) <= 8'(FRAMES))
    else $error("fill count beyond frame count");

  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_APPLY && ev_valid_r) |-> (filled_r != '0))
    else $error("eviction with no filled frame");

endmodule
